FILE: rtl/core/ultrasonic_fill_level_monitor_macros.svh
// Assertion helpers used by the monitor back end
`ifndef ULTRASONIC_FILL_LEVEL_MONITOR_MACROS_SVH
`define ULTRASONIC_FILL_LEVEL_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define UFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ufl_pkg.sv
package ufl_pkg;

  // Burst and field geometry
  localparam int SAMPLES      = 5;
  localparam int ECHO_TIMEOUT = 30000;
  localparam int ECHO_W       = 15;
  localparam int PCT_W        = 7;
  localparam int PCT_FULL     = 100;
  localparam int CNT_W        = $clog2(SAMPLES + 1);
  localparam int IDX_W        = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // Percent divider widths: num = diff * 100, dividend = 2*num + span
  localparam int NUM_W   = ECHO_W + 7;
  localparam int REM_W   = NUM_W + 1;
  localparam int DEN_W   = ECHO_W + 1;
  localparam int TRIAL_W = REM_W + 1;
  localparam int QBITS   = PCT_W + 1;
  localparam int BIT_W   = $clog2(QBITS);

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = ECHO_W;

  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_ECHO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_ECHO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PCT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_PCT  = 3'd5;

  // Level event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_FULL    = 2'd1;
  localparam logic [1:0] EV_EMPTIED = 2'd2;

  // Status codes
  localparam logic ST_LEVEL   = 1'b0;
  localparam logic ST_NO_ECHO = 1'b1;

  typedef struct packed {
    logic [ECHO_W-1:0] empty_echo_us;
    logic [ECHO_W-1:0] full_echo_us;
    logic [ECHO_W-1:0] min_valid_echo_us;
    logic [ECHO_W-1:0] max_valid_echo_us;
    logic [PCT_W-1:0]  full_threshold_pct;
    logic [PCT_W-1:0]  reset_threshold_pct;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [ECHO_W-1:0] echo;
    logic              keep;
    logic              last;
  } q_item_t;

endpackage

FILE: rtl/core/ufl_ifs.sv
// Echo sample channel
interface ufl_in_if;
  import ufl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_us;
  modport source (output valid, output echo_us, input ready);
  modport sink   (input valid, input echo_us, output ready);
endinterface

// Level result channel
interface ufl_out_if;
  import ufl_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [PCT_W-1:0] fill_percent;
  logic [1:0]       level_event;
  modport source (output valid, output status, output fill_percent, output level_event,
                  input ready);
  modport sink   (input valid, input status, input fill_percent, input level_event,
                  output ready);
endinterface

// Register write channel
interface ufl_cfg_if;
  import ufl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ufl_cfg_regs.sv
module ufl_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  ufl_cfg_if.sink        cfg_chan,
  output ufl_pkg::cfg_t  cfg_o
);
  import ufl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_chan.ready = 1'b1;
  assign wr    = cfg_chan.valid && cfg_chan.ready;
  assign cfg_o = cfg_r;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (cfg_chan.index)
        REG_EMPTY_ECHO: cfg_nxt.empty_echo_us       = cfg_chan.data;
        REG_FULL_ECHO:  cfg_nxt.full_echo_us        = cfg_chan.data;
        REG_MIN_ECHO:   cfg_nxt.min_valid_echo_us   = cfg_chan.data;
        REG_MAX_ECHO:   cfg_nxt.max_valid_echo_us   = cfg_chan.data;
        REG_FULL_PCT:   cfg_nxt.full_threshold_pct  = cfg_chan.data[PCT_W-1:0];
        REG_RESET_PCT:  cfg_nxt.reset_threshold_pct = cfg_chan.data[PCT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.empty_echo_us       <= ECHO_W'(2041);
      cfg_r.full_echo_us        <= ECHO_W'(408);
      cfg_r.min_valid_echo_us   <= ECHO_W'(117);
      cfg_r.max_valid_echo_us   <= ECHO_W'(23323);
      cfg_r.full_threshold_pct  <= PCT_W'(85);
      cfg_r.reset_threshold_pct <= PCT_W'(70);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/ufl_front.sv
module ufl_front (
  input  logic             clk,
  input  logic             rst_n,
  ufl_in_if.sink           in_chan,
  input  ufl_pkg::cfg_t    cfg_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ufl_pkg::q_item_t q_item_o
);
  import ufl_pkg::*;

  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] pos_nxt;
  logic             last;
  logic             keep;

  assign in_chan.ready = !q_full_i;
  assign q_push_o      = in_chan.valid && in_chan.ready;

  // Window check: timeout, zero and the configured min/max window
  assign keep = (in_chan.echo_us != '0) &&
                (32'(in_chan.echo_us) <= ECHO_TIMEOUT) &&
                (in_chan.echo_us >= cfg_i.min_valid_echo_us) &&
                (in_chan.echo_us <= cfg_i.max_valid_echo_us);

  assign last = (pos_r == CNT_W'(SAMPLES - 1));

  assign q_item_o.echo = in_chan.echo_us;
  assign q_item_o.keep = keep;
  assign q_item_o.last = last;

  // Burst position counter
  always_comb begin
    pos_nxt = pos_r;
    if (q_push_o) begin
      pos_nxt = last ? '0 : pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: rtl/core/ufl_queue.sv
module ufl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  ufl_pkg::q_item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ufl_pkg::q_item_t pop_item_o
);
  import ufl_pkg::*;

  q_item_t           mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_r == QCNT_W'(Q_DEPTH));
  assign valid_o    = (cnt_r != '0);
  assign pop_item_o = mem[rd_ptr_r];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/ufl_back.sv
module ufl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ufl_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  ufl_pkg::q_item_t q_item_i,
  output logic             q_pop_o,
  ufl_out_if.source        out_chan
);
  import ufl_pkg::*;
  `include "ultrasonic_fill_level_monitor_macros.svh"

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SCALE,
    ST_DIVIDE,
    ST_REPORT
  } state_t;

  state_t             state_r, state_nxt;
  logic [ECHO_W-1:0]  sorted_r [SAMPLES];
  logic [ECHO_W-1:0]  sorted_nxt [SAMPLES];
  logic [ECHO_W-1:0]  ins_vec [SAMPLES];
  logic [SAMPLES-1:0] gt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [QBITS-1:0]   q_r, q_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic               nodata_r, nodata_nxt;
  logic               zero_r, zero_nxt;
  logic               full_r, full_nxt;
  logic               base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [PCT_W-1:0]   out_pct_r, out_pct_nxt;
  logic [1:0]         out_event_r, out_event_nxt;

  logic [ECHO_W-1:0]      median;
  logic signed [ECHO_W:0] span;
  logic signed [ECHO_W:0] diff;
  logic [NUM_W-1:0]       num;
  logic [TRIAL_W-1:0]     trial;
  logic [PCT_W-1:0]       pct;
  logic [1:0]             ev;
  logic                   load;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.fill_percent = out_pct_r;
  assign out_chan.level_event  = out_event_r;

  // Sorted insertion of a kept sample (entries past the count are don't-care)
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      gt[i] = (CNT_W'(i) < cnt_r) && (sorted_r[i] > q_item_i.echo);
    end
    for (int i = 0; i < SAMPLES; i++) begin
      if ((CNT_W'(i) < cnt_r) && !gt[i]) begin
        ins_vec[i] = sorted_r[i];
      end else if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
        ins_vec[i] = sorted_r[(i > 0) ? i - 1 : 0];
      end else begin
        ins_vec[i] = q_item_i.echo;
      end
    end
  end

  // Median pick and linear scaling terms
  assign median = sorted_r[IDX_W'(cnt_r >> 1)];
  assign span   = $signed({1'b0, cfg_i.empty_echo_us}) - $signed({1'b0, cfg_i.full_echo_us});
  assign diff   = $signed({1'b0, cfg_i.empty_echo_us}) - $signed({1'b0, median});
  assign num    = NUM_W'(diff[ECHO_W-1:0]) * NUM_W'(PCT_FULL);
  assign trial  = TRIAL_W'(den_r) << bit_r;

  // Percent with clamp; top quotient bit set means far beyond full scale
  always_comb begin
    if (nodata_r || zero_r) begin
      pct = '0;
    end else if (q_r[QBITS-1] || (q_r[PCT_W-1:0] > PCT_W'(PCT_FULL))) begin
      pct = PCT_W'(PCT_FULL);
    end else begin
      pct = q_r[PCT_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    sorted_nxt     = sorted_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    q_nxt          = q_r;
    bit_nxt        = bit_r;
    nodata_nxt     = nodata_r;
    zero_nxt       = zero_r;
    full_nxt       = full_r;
    base_nxt       = base_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_pct_nxt    = out_pct_r;
    out_event_nxt  = out_event_r;
    q_pop_o        = 1'b0;
    ev             = EV_NONE;
    load           = 1'b0;

    unique case (state_r)
      ST_COLLECT: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (q_item_i.keep && (cnt_r < CNT_W'(SAMPLES))) begin
            sorted_nxt = ins_vec;
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
          if (q_item_i.last) begin
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        nodata_nxt = (cnt_r == '0);
        zero_nxt   = (span <= 0) || (diff <= 0);
        rem_nxt    = REM_W'({num, 1'b0}) + REM_W'(span[ECHO_W-1:0]);
        den_nxt    = {span[ECHO_W-1:0], 1'b0};
        q_nxt      = '0;
        bit_nxt    = BIT_W'(QBITS - 1);
        cnt_nxt    = '0;
        state_nxt  = ((cnt_r == '0) || (span <= 0) || (diff <= 0)) ? ST_REPORT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // Restoring division, one quotient bit per cycle
        if (TRIAL_W'(rem_r) >= trial) begin
          rem_nxt     = rem_r - trial[REM_W-1:0];
          q_nxt[bit_r] = 1'b1;
        end
        if (bit_r == '0) begin
          state_nxt = ST_REPORT;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      ST_REPORT: begin
        if (!out_valid_r || out_chan.ready) begin
          load = 1'b1;
          // Full / emptied hysteresis; first level burst only sets baseline
          if (!nodata_r) begin
            if (!base_r) begin
              base_nxt = 1'b1;
            end else if ((pct >= cfg_i.full_threshold_pct) && !full_r) begin
              ev       = EV_FULL;
              full_nxt = 1'b1;
            end else if ((pct <= cfg_i.reset_threshold_pct) && full_r) begin
              ev       = EV_EMPTIED;
              full_nxt = 1'b0;
            end
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = nodata_r ? ST_NO_ECHO : ST_LEVEL;
          out_pct_nxt    = pct;
          out_event_nxt  = ev;
          state_nxt      = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // State, flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      cnt_r       <= '0;
      full_r      <= 1'b0;
      base_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      full_r      <= full_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sorted_r     <= sorted_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    q_r          <= q_nxt;
    bit_r        <= bit_nxt;
    nodata_r     <= nodata_nxt;
    zero_r       <= zero_nxt;
    out_status_r <= out_status_nxt;
    out_pct_r    <= out_pct_nxt;
    out_event_r  <= out_event_nxt;
  end

  `UFL_ASSERT_IMP(a_pct_range, clk, rst_n, out_valid_r, out_pct_r <= PCT_W'(PCT_FULL), "fill percent above full scale")
  `UFL_ASSERT_IMP(a_nodata_quiet, clk, rst_n, out_valid_r && (out_status_r == ST_NO_ECHO), (out_pct_r == '0) && (out_event_r == EV_NONE), "empty burst carries a level")
  `UFL_ASSERT_NEXT(a_full_sets_flag, clk, rst_n, load && (ev == EV_FULL), full_r && base_r, "full event without full flag")
  `UFL_ASSERT_IMP(a_pop_only_collect, clk, rst_n, q_pop_o, state_r == ST_COLLECT, "queue popped while busy")

endmodule

FILE: rtl/core/ultrasonic_fill_level_monitor.sv
// Channel   Dir  Payload                                    Handshake
// in_chan   in   echo_us[14:0]                              valid/ready
// out_chan  out  status, fill_percent[6:0], level_event[1:0] valid/ready
// cfg_chan  in   index[2:0], data[14:0]                     valid/ready, ready tied high
//
// One sample per cycle while the 2-entry queue has room; the back end drains one per cycle
// while collecting. A burst end then passes through scale, 8 restoring divide steps and
// report, or scale and report alone when there is no level to divide.
// Synchronous active-low reset clears burst counters, hysteresis flags, queue and result
// valid flag and loads the register defaults; no clearing pass.
// A stalled result holds the back end in report; the queue fills and in_chan.ready drops.
module ultrasonic_fill_level_monitor (
  input  logic       clk,
  input  logic       rst_n,
  ufl_in_if.sink     in_chan,
  ufl_out_if.source  out_chan,
  ufl_cfg_if.sink    cfg_chan
);
  import ufl_pkg::*;

  cfg_t    cfg;
  q_item_t push_item;
  q_item_t pop_item;
  logic    q_full;
  logic    q_push;
  logic    q_valid;
  logic    q_pop;

  ufl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  ufl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (push_item)
  );

  ufl_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  ufl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (pop_item),
    .q_pop_o   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

FILE: test/ufl_level_compare.sv
`timescale 1ns / 1ps

// Watches the echo, result and register channels, predicts each burst result
// and compares it with what the block delivers.
module ufl_level_compare (
  input  logic        clk,
  input  logic        rst_n,
  ufl_in_if           in_mon,
  ufl_out_if          out_mon,
  ufl_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned waiting
);
  import ufl_pkg::*;

  typedef struct packed {
    logic             status;
    logic [PCT_W-1:0] fill;
    logic [1:0]       ev;
  } level_rec_t;

  // Predicted state of the monitor
  cfg_t              cfg_now;
  logic [ECHO_W-1:0] kept_echo [SAMPLES];
  int                kept_cnt;
  int                burst_pos;
  logic              is_full;
  logic              has_baseline;

  level_rec_t        level_q [$];
  int unsigned       err_cnt = 0;

  initial begin
    mismatches = 0;
    waiting    = 0;
  end

  task automatic note_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic void clear_state();
    cfg_now.empty_echo_us       = 15'd2041;
    cfg_now.full_echo_us        = 15'd408;
    cfg_now.min_valid_echo_us   = 15'd117;
    cfg_now.max_valid_echo_us   = 15'd23323;
    cfg_now.full_threshold_pct  = 7'd85;
    cfg_now.reset_threshold_pct = 7'd70;
    foreach (kept_echo[i]) kept_echo[i] = '0;
    kept_cnt     = 0;
    burst_pos    = 0;
    is_full      = 1'b0;
    has_baseline = 1'b0;
    level_q.delete();
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_EMPTY_ECHO: cfg_now.empty_echo_us       = data[ECHO_W-1:0];
      REG_FULL_ECHO:  cfg_now.full_echo_us        = data[ECHO_W-1:0];
      REG_MIN_ECHO:   cfg_now.min_valid_echo_us   = data[ECHO_W-1:0];
      REG_MAX_ECHO:   cfg_now.max_valid_echo_us   = data[ECHO_W-1:0];
      REG_FULL_PCT:   cfg_now.full_threshold_pct  = data[PCT_W-1:0];
      REG_RESET_PCT:  cfg_now.reset_threshold_pct = data[PCT_W-1:0];
      default: ;
    endcase
  endfunction

  // Middle of the kept widths after an ascending insertion sort
  function automatic logic [ECHO_W-1:0] burst_median();
    logic [ECHO_W-1:0] sorted [SAMPLES];
    logic [ECHO_W-1:0] t;
    int j;
    sorted = kept_echo;
    for (int i = 1; i < kept_cnt; i++) begin
      t = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > t) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = t;
    end
    return sorted[kept_cnt/2];
  endfunction

  // Linear map to percent, rounded half up, clamped; zero on a bad span or level
  function automatic logic [PCT_W-1:0] level_from_echo(input logic [ECHO_W-1:0] e);
    longint span, num, q;
    span = longint'(cfg_now.empty_echo_us) - longint'(cfg_now.full_echo_us);
    num  = (longint'(cfg_now.empty_echo_us) - longint'(e)) * 100;
    if (span <= 0 || num <= 0) return '0;
    q = (2 * num + span) / (2 * span);
    if (q > PCT_FULL) q = PCT_FULL;
    return PCT_W'(q);
  endfunction

  // One echo transaction; queues a result when it closes a burst
  function automatic void take_echo(input logic [ECHO_W-1:0] e);
    level_rec_t r;
    if (e != 0 && e <= ECHO_TIMEOUT &&
        e >= cfg_now.min_valid_echo_us && e <= cfg_now.max_valid_echo_us &&
        kept_cnt < SAMPLES) begin
      kept_echo[kept_cnt] = e;
      kept_cnt++;
    end
    burst_pos++;
    if (burst_pos < SAMPLES) return;

    r.status = ST_LEVEL;
    r.fill   = '0;
    r.ev     = EV_NONE;
    if (kept_cnt == 0) begin
      r.status = ST_NO_ECHO;
    end else begin
      r.fill = level_from_echo(burst_median());
      // first level only sets the baseline
      if (!has_baseline) begin
        has_baseline = 1'b1;
      end else if (r.fill >= cfg_now.full_threshold_pct && !is_full) begin
        r.ev    = EV_FULL;
        is_full = 1'b1;
      end else if (r.fill <= cfg_now.reset_threshold_pct && is_full) begin
        r.ev    = EV_EMPTIED;
        is_full = 1'b0;
      end
    end
    burst_pos = 0;
    kept_cnt  = 0;
    level_q.push_back(r);
  endfunction

  task automatic check_result();
    level_rec_t want;
    if (level_q.size() == 0) begin
      note_error($sformatf("result with nothing expected: status %0d fill %0d event %0d",
                           out_mon.status, out_mon.fill_percent, out_mon.level_event));
      return;
    end
    want = level_q.pop_front();
    if (out_mon.status !== want.status)
      note_error($sformatf("status %0d, expected %0d", out_mon.status, want.status));
    if (out_mon.fill_percent !== want.fill)
      note_error($sformatf("fill_percent %0d, expected %0d", out_mon.fill_percent, want.fill));
    if (out_mon.level_event !== want.ev)
      note_error($sformatf("level_event %0d, expected %0d", out_mon.level_event, want.ev));
  endtask

  // Results are popped before a same-edge echo can push its own
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_reg(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) take_echo(in_mon.echo_us);
    end
    waiting    <= level_q.size();
    mismatches <= err_cnt;
  end

endmodule

FILE: test/ultrasonic_fill_level_monitor_test.sv
`timescale 1ns / 1ps

module ultrasonic_fill_level_monitor_test;
  import ufl_pkg::*;

  localparam int LIMIT_CYCLES  = 800_000;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int FIXED_BURSTS  = 8;
  localparam int RAND_PHASES   = 12;
  localparam int RAND_BURSTS   = 18;
  localparam int PRESS_BURSTS  = 12;
  localparam int ECHO_MAX      = (1 << ECHO_W) - 1;

  // Register indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned err_total;
  int unsigned exp_left;

  // Stimulus shaping
  cfg_t cur_cfg;
  bit   quiet_mode;
  bit   press_go;
  bit   press_done;

  ufl_in_if  in_if ();
  ufl_out_if out_if ();
  ufl_cfg_if cfg_if ();

  ultrasonic_fill_level_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  ufl_level_compare level_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .mismatches (err_total),
    .waiting    (exp_left)
  );

  always #6 clk = ~clk;

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 40);
  endfunction

  // Widths that the window throws away
  function automatic logic [ECHO_W-1:0] pick_noise();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ECHO_W'($urandom_range(ECHO_TIMEOUT + 1, ECHO_MAX));
      2: return (cur_cfg.min_valid_echo_us == 0) ? '0 :
                ECHO_W'($urandom_range(0, cur_cfg.min_valid_echo_us - 1));
      default: return ECHO_W'($urandom_range(cur_cfg.max_valid_echo_us + 1, ECHO_MAX));
    endcase
  endfunction

  // Widths mostly around the calibration span, some at the window edges
  function automatic logic [ECHO_W-1:0] pick_echo();
    int r, lo, hi;
    lo = (cur_cfg.full_echo_us < cur_cfg.empty_echo_us) ? cur_cfg.full_echo_us
                                                        : cur_cfg.empty_echo_us;
    hi = (cur_cfg.full_echo_us < cur_cfg.empty_echo_us) ? cur_cfg.empty_echo_us
                                                        : cur_cfg.full_echo_us;
    lo = (lo > 201) ? lo - 200 : 1;
    hi = (hi + 200 < ECHO_TIMEOUT) ? hi + 200 : ECHO_TIMEOUT;
    r = $urandom_range(0, 99);
    if (r < 60) return ECHO_W'($urandom_range(lo, hi));
    if (r < 75) return ECHO_W'($urandom_range(cur_cfg.min_valid_echo_us,
                                               cur_cfg.max_valid_echo_us));
    if (r < 82) begin
      case ($urandom_range(0, 5))
        0: return cur_cfg.min_valid_echo_us;
        1: return cur_cfg.max_valid_echo_us;
        2: return cur_cfg.min_valid_echo_us - 1'b1;
        3: return cur_cfg.max_valid_echo_us + 1'b1;
        4: return ECHO_W'(ECHO_TIMEOUT);
        default: return ECHO_W'(ECHO_TIMEOUT + 1);
      endcase
    end
    if (r < 88) return '0;
    return ECHO_W'($urandom_range(0, ECHO_MAX));
  endfunction

  // One echo transaction; valid stays up when the next one follows at once
  task automatic send_echo(input logic [ECHO_W-1:0] e);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.echo_us <= e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic run_bursts(input int n);
    bit noisy;
    for (int b = 0; b < n; b++) begin
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < SAMPLES; k++) send_echo(noisy ? pick_noise() : pick_echo());
    end
  endtask

  // Stop sending, wait for every result, then let the back end go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (exp_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_EMPTY_ECHO: cur_cfg.empty_echo_us       = data;
      REG_FULL_ECHO:  cur_cfg.full_echo_us        = data;
      REG_MIN_ECHO:   cur_cfg.min_valid_echo_us   = data;
      REG_MAX_ECHO:   cur_cfg.max_valid_echo_us   = data;
      REG_FULL_PCT:   cur_cfg.full_threshold_pct  = data[PCT_W-1:0];
      REG_RESET_PCT:  cur_cfg.reset_threshold_pct = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [CFG_DAT_W-1:0] e, f, mn, mx, fth, rth,
                           input bit spare);
    if (spare) begin
      write_reg(REG_SPARE_A, CFG_DAT_W'($urandom_range(0, ECHO_MAX)));
      write_reg(REG_SPARE_B, CFG_DAT_W'($urandom_range(0, ECHO_MAX)));
    end
    write_reg(REG_EMPTY_ECHO, e);
    write_reg(REG_FULL_ECHO, f);
    write_reg(REG_MIN_ECHO, mn);
    write_reg(REG_MAX_ECHO, mx);
    write_reg(REG_FULL_PCT, fth);
    write_reg(REG_RESET_PCT, rth);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly a sane calibration, sometimes raw register noise
  task automatic apply_random_cfg();
    int e, f, mn, mx, fth, rth;
    if ($urandom_range(0, 3) == 0) begin
      e   = $urandom_range(0, ECHO_MAX);
      f   = $urandom_range(0, ECHO_MAX);
      mn  = $urandom_range(0, ECHO_MAX);
      mx  = $urandom_range(0, ECHO_MAX);
      fth = $urandom_range(0, ECHO_MAX);
      rth = $urandom_range(0, ECHO_MAX);
    end else begin
      f   = $urandom_range(0, 20000);
      e   = f + $urandom_range(1, 8000);
      mn  = $urandom_range(0, f);
      mx  = $urandom_range(e, ECHO_TIMEOUT);
      fth = $urandom_range(50, 100);
      rth = $urandom_range(0, fth);
    end
    apply_cfg(CFG_DAT_W'(e), CFG_DAT_W'(f), CFG_DAT_W'(mn), CFG_DAT_W'(mx),
              CFG_DAT_W'(fth), CFG_DAT_W'(rth), 1'b1);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall, run;
    out_if.ready = 1'b0;
    forever begin
      if (press_go && !press_done) begin
        stall      = HOLD_CYCLES;
        press_done = 1'b1;
      end else begin
        stall = pick_stall();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [ECHO_W-1:0] opening [$];
    opening = '{
      // no echo at all before any baseline
      15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
      // empty bin sets the baseline
      15'd2041,  15'd2041,  15'd2041,  15'd2041,  15'd2041,
      // full bin fires the full event
      15'd408,   15'd408,   15'd408,   15'd408,   15'd408,
      // timeouts and widths just outside the window
      15'd0,     15'd30001, 15'd32767, 15'd116,   15'd23324,
      // window edges and beyond calibration, median lands near half
      15'd117,   15'd23323, 15'd1225,  15'd2041,  15'd408,
      // two kept widths, upper one is taken
      15'd408,   15'd0,     15'd1000,  15'd0,     15'd0
    };

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.echo_us = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    quiet_mode    = 1'b0;
    press_go      = 1'b0;
    cur_cfg.empty_echo_us       = 15'd2041;
    cur_cfg.full_echo_us        = 15'd408;
    cur_cfg.min_valid_echo_us   = 15'd117;
    cur_cfg.max_valid_echo_us   = 15'd23323;
    cur_cfg.full_threshold_pct  = 7'd85;
    cur_cfg.reset_threshold_pct = 7'd70;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bursts on the reset calibration
    foreach (opening[i]) send_echo(opening[i]);
    settle();

    // Zero lower bound: a zero width still counts as a timeout
    apply_cfg(15'd2041, 15'd408, 15'd0, 15'd30000, 15'd85, 15'd70, 1'b0);
    run_bursts(FIXED_BURSTS);
    settle();
    // Inverted span, thresholds at both ends
    apply_cfg(15'd408, 15'd2041, 15'd117, 15'd23323, 15'd0, 15'd127, 1'b0);
    run_bursts(FIXED_BURSTS);
    settle();
    // Window with min above max
    apply_cfg(15'd30000, 15'd0, 15'd20000, 15'd100, 15'd85, 15'd70, 1'b0);
    run_bursts(FIXED_BURSTS);
    settle();
    // Widest values; full threshold data has its upper bits set
    apply_cfg(15'h7FFF, 15'd0, 15'd1, 15'h7FFF, 15'h7FFF, 15'd0, 1'b1);
    run_bursts(FIXED_BURSTS);
    settle();
    // One microsecond span, thresholds at the top
    apply_cfg(15'd3000, 15'd2999, 15'd2990, 15'd3010, 15'd100, 15'd99, 1'b0);
    run_bursts(FIXED_BURSTS);
    settle();
    // Zero span
    apply_cfg(15'd5000, 15'd5000, 15'd0, 15'h7FFF, 15'd50, 15'd50, 1'b0);
    run_bursts(FIXED_BURSTS);
    settle();

    // Back to reset calibration; long result hold-off while echoes keep coming
    apply_cfg(15'd2041, 15'd408, 15'd117, 15'd23323, 15'd85, 15'd70, 1'b0);
    quiet_mode = 1'b1;
    press_go   = 1'b1;
    run_bursts(PRESS_BURSTS);
    quiet_mode = 1'b0;
    settle();

    // Random calibrations; every third phase without sender gaps
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_random_cfg();
      quiet_mode = (p % 3 == 1);
      run_bursts(RAND_BURSTS);
      quiet_mode = 1'b0;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_total == 0 && exp_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
